// ===== src/ppm_pkg.sv =====
// Package for the PPM P6 stream parser: sizes, character codes, error codes, helpers.
package ppm_pkg;

    localparam int DIM_BITS = 16;
    localparam int MAXV_BITS = 17;
    localparam int OUT_DIM_BITS = 16;

    localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
    localparam logic [MAXV_BITS-1:0] MAXV_SAT = {MAXV_BITS{1'b1}};
    localparam logic [MAXV_BITS-1:0] MAXV_WIDE_LIMIT = MAXV_BITS'(65536);
    localparam logic [MAXV_BITS-1:0] MAXV_BYTE_LIMIT = MAXV_BITS'(255);

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_6 = 8'h36;
    localparam logic [7:0] CH_HASH = 8'd35;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_WIDTH     = 3'd2,
        ERR_HEIGHT    = 3'd3,
        ERR_MAX_LARGE = 3'd4,
        ERR_NO_DELIM  = 3'd5
    } err_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // acc*10 + digit, saturating at the limit
    function automatic logic [DIM_BITS-1:0] acc_dim(input logic [DIM_BITS-1:0] acc,
                                                     input logic [7:0] c);
        logic [DIM_BITS+4:0] v;
        v = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + (DIM_BITS+5)'(c - CH_ZERO);
        acc_dim = (v > (DIM_BITS+5)'(DIM_MAX)) ? DIM_MAX : v[DIM_BITS-1:0];
    endfunction

    function automatic logic [MAXV_BITS-1:0] acc_maxv(input logic [MAXV_BITS-1:0] acc,
                                                       input logic [7:0] c);
        logic [MAXV_BITS+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (MAXV_BITS+4)'(c - CH_ZERO);
        acc_maxv = (v > (MAXV_BITS+4)'(MAXV_SAT)) ? MAXV_SAT : v[MAXV_BITS-1:0];
    endfunction

endpackage

// ===== src/ppm_p6_stream_parser.sv =====
// Top level of the PPM P6 stream parser: header parse, raster to pixels, error report.
//
// Input channel: one file byte per item (byte_value), with start_of_file set on the
// first byte of a file, which restarts the parser. Output channel: one pixel item
// (red, green, blue, column, row, last_pixel, error_code = 0) per completed RGB
// triple, or one error item with all pixel fields zero and error_code 1..4.
// Header bytes, comment bytes, skipped low bytes of wide samples and trailing bytes
// produce no item. After an error, bytes are dropped until start_of_file.
// Output items are registered: an item appears in the cycle after its completing byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the next parse state is computed
// combinationally between the input handshake and the output register.
// Stall: the output register holds its item while out_ready is low; in_ready is low
// only while that register is full and not being taken.
// Reset: parser returns to expecting the 'P' magic byte, output register empties.
module ppm_p6_stream_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        byte_value,
    input  logic                              start_of_file,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic [ppm_pkg::OUT_DIM_BITS-1:0]  column,
    output logic [ppm_pkg::OUT_DIM_BITS-1:0]  row,
    output logic                              last_pixel,
    output logic [2:0]                        error_code
);
    import ppm_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC_P = 4'd0,
        PH_MAGIC_6 = 4'd1,
        PH_PRE_W   = 4'd2,
        PH_COMMENT = 4'd3,
        PH_WIDTH   = 4'd4,
        PH_SEP_H   = 4'd5,
        PH_HEIGHT  = 4'd6,
        PH_SEP_M   = 4'd7,
        PH_MAXV    = 4'd8,
        PH_RASTER  = 4'd9,
        PH_DONE    = 4'd10,
        PH_HALT    = 4'd11
    } phase_t;

    phase_t                phase_reg, phase_next, phase_cur;
    logic [DIM_BITS-1:0]   width_reg, width_next, width_cur;
    logic [DIM_BITS-1:0]   height_reg, height_next, height_cur;
    logic [MAXV_BITS-1:0]  maxv_reg, maxv_next, maxv_cur;
    logic                  wide_reg, wide_next;
    logic [2:0]            pos_reg, pos_next;
    logic [7:0]            held_red_reg, held_red_next;
    logic [7:0]            held_green_reg, held_green_next;
    logic [DIM_BITS-1:0]   col_reg, col_next;
    logic [DIM_BITS-1:0]   row_cnt_reg, row_cnt_next;

    logic                  out_valid_reg;
    logic [7:0]            red_reg, green_reg, blue_reg;
    logic [OUT_DIM_BITS-1:0] column_reg, row_reg;
    logic                  last_reg;
    err_t                  err_reg;

    logic                  emit;
    err_t                  emit_err;
    logic                  emit_last;
    logic [1:0]            sel;
    logic                  take;
    logic [DIM_BITS:0]     col_inc, row_inc;
    logic [31:0]           col_ext, row_ext;

    logic accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    assign col_inc = {1'b0, col_reg} + (DIM_BITS+1)'(1);
    assign row_inc = {1'b0, row_cnt_reg} + (DIM_BITS+1)'(1);
    assign col_ext = 32'(col_reg);
    assign row_ext = 32'(row_cnt_reg);

    always_comb
    begin
        phase_cur  = start_of_file ? PH_MAGIC_P : phase_reg;
        width_cur  = start_of_file ? '0 : width_reg;
        height_cur = start_of_file ? '0 : height_reg;
        maxv_cur   = start_of_file ? '0 : maxv_reg;

        phase_next      = phase_cur;
        width_next      = width_cur;
        height_next     = height_cur;
        maxv_next       = maxv_cur;
        wide_next       = wide_reg;
        pos_next        = pos_reg;
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        col_next        = col_reg;
        row_cnt_next    = row_cnt_reg;
        emit            = 1'b0;
        emit_err        = ERR_NONE;
        emit_last       = 1'b0;
        sel             = 2'd0;
        take            = 1'b0;

        case (phase_cur)
            PH_MAGIC_P:
            begin
                if (byte_value != CH_P)
                begin
                    emit = 1'b1;
                    emit_err = ERR_MAGIC;
                end
                else
                    phase_next = PH_MAGIC_6;
            end
            PH_MAGIC_6:
            begin
                if (byte_value != CH_6)
                begin
                    emit = 1'b1;
                    emit_err = ERR_MAGIC;
                end
                else
                    phase_next = PH_PRE_W;
            end
            PH_PRE_W:
            begin
                if (is_ws(byte_value))
                    phase_next = PH_PRE_W;
                else if (byte_value == CH_HASH)
                    phase_next = PH_COMMENT;
                else if (!is_digit(byte_value))
                begin
                    emit = 1'b1;
                    emit_err = ERR_WIDTH;
                end
                else
                begin
                    width_next = acc_dim(width_cur, byte_value);
                    phase_next = PH_WIDTH;
                end
            end
            PH_COMMENT:
            begin
                if (byte_value == CH_LF)
                    phase_next = PH_PRE_W;
            end
            PH_WIDTH:
            begin
                if (is_ws(byte_value))
                    phase_next = PH_SEP_H;
                else if (!is_digit(byte_value))
                begin
                    emit = 1'b1;
                    emit_err = ERR_WIDTH;
                end
                else
                    width_next = acc_dim(width_cur, byte_value);
            end
            PH_SEP_H, PH_HEIGHT:
            begin
                if (is_ws(byte_value))
                begin
                    if (phase_cur == PH_HEIGHT)
                        phase_next = PH_SEP_M;
                end
                else if (!is_digit(byte_value))
                begin
                    emit = 1'b1;
                    emit_err = ERR_HEIGHT;
                end
                else
                begin
                    height_next = acc_dim(height_cur, byte_value);
                    phase_next = PH_HEIGHT;
                end
            end
            PH_SEP_M:
            begin
                if (is_ws(byte_value))
                    phase_next = PH_SEP_M;
                else if (!is_digit(byte_value))
                begin
                    emit = 1'b1;
                    emit_err = ERR_HEIGHT;
                end
                else
                begin
                    maxv_next = acc_maxv(maxv_cur, byte_value);
                    phase_next = PH_MAXV;
                end
            end
            PH_MAXV:
            begin
                if (is_digit(byte_value))
                    maxv_next = acc_maxv(maxv_cur, byte_value);
                else if (!is_ws(byte_value))
                begin
                    emit = 1'b1;
                    emit_err = ERR_HEIGHT;
                end
                else if (maxv_cur > MAXV_WIDE_LIMIT)
                begin
                    emit = 1'b1;
                    emit_err = ERR_MAX_LARGE;
                end
                else
                begin
                    wide_next    = maxv_cur > MAXV_BYTE_LIMIT;
                    pos_next     = 3'd0;
                    col_next     = '0;
                    row_cnt_next = '0;
                    phase_next   = (width_cur == '0 || height_cur == '0) ? PH_DONE
                                                                       : PH_RASTER;
                end
            end
            PH_RASTER:
            begin
                if (wide_reg)
                begin
                    // high bytes at 0, 2, 4; low bytes skipped
                    pos_next = (pos_reg == 3'd5) ? 3'd0 : pos_reg + 3'd1;
                    take = !pos_reg[0];
                    sel = pos_reg[2:1];
                end
                else
                begin
                    pos_next = (pos_reg >= 3'd2) ? 3'd0 : pos_reg + 3'd1;
                    take = 1'b1;
                    sel = pos_reg[1:0];
                end
                if (take)
                begin
                    case (sel)
                        2'd0:
                            held_red_next = byte_value;
                        2'd1:
                            held_green_next = byte_value;
                        default:
                        begin
                            emit = 1'b1;
                            emit_last = col_inc == {1'b0, width_reg} &&
                                        row_inc == {1'b0, height_reg};
                            if (col_inc >= {1'b0, width_reg})
                            begin
                                col_next = '0;
                                row_cnt_next = row_inc[DIM_BITS-1:0];
                                if (row_inc >= {1'b0, height_reg})
                                    phase_next = PH_DONE;
                            end
                            else
                                col_next = col_inc[DIM_BITS-1:0];
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        if (emit && emit_err != ERR_NONE)
            phase_next = PH_HALT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC_P;
            width_reg      <= '0;
            height_reg     <= '0;
            maxv_reg       <= '0;
            wide_reg       <= 1'b0;
            pos_reg        <= 3'd0;
            held_red_reg   <= 8'd0;
            held_green_reg <= 8'd0;
            col_reg        <= '0;
            row_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            red_reg        <= 8'd0;
            green_reg      <= 8'd0;
            blue_reg       <= 8'd0;
            column_reg     <= '0;
            row_reg        <= '0;
            last_reg       <= 1'b0;
            err_reg        <= ERR_NONE;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                maxv_reg       <= maxv_next;
                wide_reg       <= wide_next;
                pos_reg        <= pos_next;
                held_red_reg   <= held_red_next;
                held_green_reg <= held_green_next;
                col_reg        <= col_next;
                row_cnt_reg    <= row_cnt_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
                err_reg       <= emit_err;
                if (emit_err == ERR_NONE)
                begin
                    red_reg    <= held_red_reg;
                    green_reg  <= held_green_reg;
                    blue_reg   <= byte_value;
                    column_reg <= col_ext[OUT_DIM_BITS-1:0];
                    row_reg    <= row_ext[OUT_DIM_BITS-1:0];
                    last_reg   <= emit_last;
                end
                else
                begin
                    red_reg    <= 8'd0;
                    green_reg  <= 8'd0;
                    blue_reg   <= 8'd0;
                    column_reg <= '0;
                    row_reg    <= '0;
                    last_reg   <= 1'b0;
                end
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign column     = column_reg;
    assign row        = row_reg;
    assign last_pixel = last_reg;
    assign error_code = err_reg;

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg != ERR_NONE |->
            red_reg == 8'd0 && green_reg == 8'd0 && blue_reg == 8'd0 &&
            column_reg == '0 && row_reg == '0 && !last_reg)
        else $error("error item carries pixel data");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg != ERR_NONE |-> phase_reg == PH_HALT)
        else $error("parser not halted after error item");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> phase_reg == PH_DONE)
        else $error("last pixel emitted but raster not finished");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> err_reg == ERR_NONE)
        else $error("last mark on an error item");
`endif

endmodule
